>>> rtl/core/ubxfc_pkg.sv
`default_nettype none
package ubxfc_pkg;

	localparam int unsigned ByteW    = 8;
	localparam int unsigned LenW     = 16;
	localparam int unsigned RemainW  = LenW + 1;
	localparam int unsigned CfgIdxW  = 8;
	localparam int unsigned InDataW  = 8;
	localparam int unsigned ResBits  = 1 + 6 * ByteW + LenW;
	localparam int unsigned OutDataW = ((ResBits + 7) / 8) * 8;

	localparam logic [CfgIdxW-1:0] REG_SYNC_FIRST  = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] REG_SYNC_SECOND = CfgIdxW'(1);

	localparam logic [ByteW-1:0] SYNC_FIRST_RST  = 8'd181;
	localparam logic [ByteW-1:0] SYNC_SECOND_RST = 8'd98;

	typedef enum logic [2:0] {
		POS_HUNT1  = 3'd0,
		POS_HUNT2  = 3'd1,
		POS_CLASS  = 3'd2,
		POS_ID     = 3'd3,
		POS_LEN_LO = 3'd4,
		POS_LEN_HI = 3'd5,
		POS_BODY   = 3'd6
	} pos_t;

	typedef struct packed {
		logic [ByteW-1:0] recv_sum_b;
		logic [ByteW-1:0] recv_sum_a;
		logic [ByteW-1:0] calc_sum_b;
		logic [ByteW-1:0] calc_sum_a;
		logic [LenW-1:0]  payload_length;
		logic [ByteW-1:0] msg_id;
		logic [ByteW-1:0] msg_class;
		logic             frame_ok;
	} res_t;

endpackage
`default_nettype wire

>>> rtl/core/ubxfc_parser.sv
`default_nettype none
module ubxfc_parser
	import ubxfc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [ByteW-1:0] rx_byte,
	input  wire logic [ByteW-1:0] sync_first,
	input  wire logic [ByteW-1:0] sync_second,
	output logic                  emit,
	output res_t                  result
);

	pos_t               pos_q, pos_d;
	logic [RemainW-1:0] remain_q, remain_d;
	logic [ByteW-1:0]   sum_a_q, sum_a_d;
	logic [ByteW-1:0]   sum_b_q, sum_b_d;
	logic [ByteW-1:0]   class_q, class_d;
	logic [ByteW-1:0]   id_q, id_d;
	logic [LenW-1:0]    len_q, len_d;
	logic [ByteW-1:0]   chk_a_q, chk_a_d;
	logic [ByteW-1:0]   acc_a;
	logic [ByteW-1:0]   acc_b;
	logic [LenW-1:0]    len_full;

	assign acc_a    = sum_a_q + rx_byte;
	assign acc_b    = sum_b_q + acc_a;
	assign len_full = {rx_byte, len_q[ByteW-1:0]};

	// A result is due when the second checksum byte is the next one in.
	assign emit = (pos_q == POS_BODY) && (remain_q == RemainW'(1));

	always_comb begin
		pos_d    = pos_q;
		remain_d = remain_q;
		sum_a_d  = sum_a_q;
		sum_b_d  = sum_b_q;
		class_d  = class_q;
		id_d     = id_q;
		len_d    = len_q;
		chk_a_d  = chk_a_q;
		unique case (pos_q)
			POS_HUNT1: begin
				pos_d    = (rx_byte == sync_first) ? POS_HUNT2 : POS_HUNT1;
				remain_d = '0;
				sum_a_d  = '0;
				sum_b_d  = '0;
				class_d  = '0;
				id_d     = '0;
				len_d    = '0;
				chk_a_d  = '0;
			end
			POS_HUNT2: begin
				if (rx_byte == sync_second) begin
					pos_d = POS_CLASS;
				end else begin
					pos_d = POS_HUNT1;
				end
			end
			POS_CLASS: begin
				class_d = rx_byte;
				sum_a_d = acc_a;
				sum_b_d = acc_b;
				pos_d   = POS_ID;
			end
			POS_ID: begin
				id_d    = rx_byte;
				sum_a_d = acc_a;
				sum_b_d = acc_b;
				pos_d   = POS_LEN_LO;
			end
			POS_LEN_LO: begin
				len_d   = {{(LenW-ByteW){1'b0}}, rx_byte};
				sum_a_d = acc_a;
				sum_b_d = acc_b;
				pos_d   = POS_LEN_HI;
			end
			POS_LEN_HI: begin
				len_d    = len_full;
				sum_a_d  = acc_a;
				sum_b_d  = acc_b;
				remain_d = {1'b0, len_full} + RemainW'(2);
				pos_d    = POS_BODY;
			end
			POS_BODY: begin
				if (remain_q > RemainW'(2)) begin
					sum_a_d  = acc_a;
					sum_b_d  = acc_b;
					remain_d = remain_q - RemainW'(1);
				end else if (remain_q == RemainW'(2)) begin
					chk_a_d  = rx_byte;
					remain_d = RemainW'(1);
				end else begin
					pos_d = POS_HUNT1;
				end
			end
			default: begin
				pos_d = POS_HUNT1;
			end
		endcase
		// Leaving the frame by any path other than the first sync clears everything.
		if (pos_d == POS_HUNT1) begin
			remain_d = '0;
			sum_a_d  = '0;
			sum_b_d  = '0;
			class_d  = '0;
			id_d     = '0;
			len_d    = '0;
			chk_a_d  = '0;
		end
	end

	always_comb begin
		result.frame_ok       = (chk_a_q == sum_a_q) && (rx_byte == sum_b_q);
		result.msg_class      = class_q;
		result.msg_id         = id_q;
		result.payload_length = len_q;
		result.calc_sum_a     = sum_a_q;
		result.calc_sum_b     = sum_b_q;
		result.recv_sum_a     = chk_a_q;
		result.recv_sum_b     = rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_HUNT1;
			remain_q <= '0;
			sum_a_q  <= '0;
			sum_b_q  <= '0;
			class_q  <= '0;
			id_q     <= '0;
			len_q    <= '0;
			chk_a_q  <= '0;
		end else if (step) begin
			pos_q    <= pos_d;
			remain_q <= remain_d;
			sum_a_q  <= sum_a_d;
			sum_b_q  <= sum_b_d;
			class_q  <= class_d;
			id_q     <= id_d;
			len_q    <= len_d;
			chk_a_q  <= chk_a_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/ubxfc_out_reg.sv
`default_nettype none
module ubxfc_out_reg
	import ubxfc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire res_t                result,
	output logic                     can_load,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [OutDataW-1:0]      m_tdata
);

	logic valid_q;
	res_t data_q;

	assign can_load = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {{(OutDataW-ResBits){1'b0}}, data_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			data_q <= result;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/ubx_frame_checker_core.sv
// Frame checker for a binary serial protocol with two sync bytes and an
// 8-bit Fletcher checksum pair.
// The slave stream carries one received byte per item in s_tdata.  The
// master stream carries one item per finished frame: the pass flag, the
// class, id and length from the header, and the computed and received
// checksum bytes.  Bytes that do not complete a frame give no item.
// The sync byte values are set through the write port (index 0 and 1); the user
// must write them only while the block is idle, which the block itself does not enforce.
// A byte is taken into an input register, then stepped through the
// parser, whose running sums and byte counter handle one byte per cycle.
// A frame result passes from the input register to the output register, and
// one byte per cycle is sustained while the master side does not stall.
// When the master side stalls, the result waits in the output register and
// further bytes are still taken; only the last byte of a following frame
// waits in the input register until the output register frees up.
// Reset clears the parser back to hunting for the first sync byte, drops
// any pending item and restores the default sync values.
`default_nettype none
module ubx_frame_checker_core
	import ubxfc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [InDataW-1:0]  s_tdata,   // rx_byte[7:0]
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// frame_ok[0], msg_class[8:1], msg_id[16:9], payload_length[32:17],
	// calc_sum_a[40:33], calc_sum_b[48:41], recv_sum_a[56:49],
	// recv_sum_b[64:57], zero fill above
	output logic [OutDataW-1:0]      m_tdata,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [ByteW-1:0]    cfg_data
);

	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic [ByteW-1:0] sync_first_q;
	logic [ByteW-1:0] sync_second_q;
	logic             emit;
	logic             can_load;
	logic             step;
	res_t             result;

	assign step     = valid_s1 && (!emit || can_load);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				REG_SYNC_SECOND: sync_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[ByteW-1:0];
		end
	end

	ubxfc_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.rx_byte     (byte_s1),
		.sync_first  (sync_first_q),
		.sync_second (sync_second_q),
		.emit        (emit),
		.result      (result)
	);

	ubxfc_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step && emit),
		.result   (result),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_emit_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit |=> m_tvalid)
		else $error("finished frame did not reach the output register");

	a_ok_matches_sums: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[0] == ((m_tdata[56:49] == m_tdata[40:33]) &&
			(m_tdata[64:57] == m_tdata[48:41])))
		else $error("pass flag disagrees with the checksum fields");

	a_no_step_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && emit && m_tvalid && !m_tready |-> !step)
		else $error("frame end stepped while the output register was full");

endmodule
`default_nettype wire
